>>> design/ordered_list_store_assert.svh
// Assertion macros for the ordered list store.
// Used by ordered_list_store.sv; expects i_clk and i_rst_n in scope.
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define OLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition in one cycle implies another in the following cycle.
`define OLS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

>>> design/ols_pkg.sv
// Types and constants for the ordered list store.
// No dependencies; used by ordered_list_store.sv.
package ols_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 16;
    localparam int LEN_W = 5;

    localparam logic signed [VAL_W-1:0] NO_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        t_status                 status;
        logic [LEN_W-1:0]        length;
    } t_res;

endpackage

>>> design/ordered_list_store.sv
// Ordered list store: top level with list memory and operation sequencer.
// Depends on ols_pkg and ordered_list_store_assert.svh.

// The store holds up to CAPACITY signed 32-bit values in one memory with a
// single write port and a single registered read port, and handles one
// request at a time. Each entry moves one position by a read and then a
// write, so the memory port sets the cost of a shift. A read out of range
// or an insert/append into a full store goes straight to S_DONE. The next
// request is taken only after S_DONE has moved the result to the output
// register. A finished result sits in an output register until taken; the
// next request is accepted meanwhile. The length field carries the entry
// count modulo 32.
module ordered_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ols_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output ols_pkg::t_res o_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_WR,
        S_RM_RD,
        S_RM_CMP,
        S_RM_SH,
        S_RM_MV,
        S_RD,
        S_RD_GET,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [CNT_W-1:0]                r_idx, n_idx;
    logic [CNT_W-1:0]                r_tgt, n_tgt;
    logic signed [ols_pkg::VAL_W-1:0] r_value, n_value;
    ols_pkg::t_res                   r_res, n_res;
    ols_pkg::t_res                   r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic signed [ols_pkg::VAL_W-1:0] r_mem [CAPACITY];
    logic signed [ols_pkg::VAL_W-1:0] r_rdata;

    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    logic signed [ols_pkg::VAL_W-1:0] mem_wdata;
    logic                            mem_re;
    logic [IDX_W-1:0]                mem_raddr;

    logic                            req_take;
    logic                            full;
    logic [ols_pkg::POS_W-1:0]       count_pos;
    logic [CNT_W-1:0]                idx_next;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_take    = i_req_valid && o_req_ready;
    assign full        = (r_count == CNT_W'(CAPACITY));
    assign count_pos   = ols_pkg::POS_W'(r_count);
    assign idx_next    = CNT_W'(r_idx + 1'b1);

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_tgt       = r_tgt;
        n_value     = r_value;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = IDX_W'(r_idx);
        mem_wdata   = r_rdata;
        mem_re      = 1'b0;
        mem_raddr   = IDX_W'(r_idx);

        // drop the held result once taken; S_DONE may load a new one
        if (i_res_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_value = i_req.value;
                    case (i_req.op)
                        ols_pkg::OP_APPEND, ols_pkg::OP_INSERT: begin
                            if (full) begin
                                n_res   = '{ols_pkg::NO_VALUE, ols_pkg::ST_FULL,
                                            ols_pkg::LEN_W'(r_count)};
                                n_state = S_DONE;
                            end else begin
                                n_idx = r_count;
                                // clamp insert position to the tail
                                if (i_req.op == ols_pkg::OP_APPEND ||
                                        i_req.position > count_pos) begin
                                    n_tgt = r_count;
                                end else begin
                                    n_tgt = CNT_W'(i_req.position);
                                end
                                n_state = S_INS;
                            end
                        end
                        ols_pkg::OP_REMOVE: begin
                            n_idx   = '0;
                            n_state = S_RM_RD;
                        end
                        ols_pkg::OP_READ: begin
                            if (i_req.position < count_pos) begin
                                n_idx   = CNT_W'(i_req.position);
                                n_state = S_RD;
                            end else begin
                                n_res   = '{ols_pkg::NO_VALUE, ols_pkg::ST_MISS,
                                            ols_pkg::LEN_W'(r_count)};
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_idx == r_tgt) begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(r_tgt);
                    mem_wdata = r_value;
                    n_count   = CNT_W'(r_count + 1'b1);
                    n_res     = '{ols_pkg::NO_VALUE, ols_pkg::ST_DONE,
                                  ols_pkg::LEN_W'(n_count)};
                    n_state   = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(r_idx - 1'b1);
                    n_state   = S_INS_WR;
                end
            end
            S_INS_WR: begin
                // move the entry one place toward the tail
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(r_idx);
                mem_wdata = r_rdata;
                n_idx     = CNT_W'(r_idx - 1'b1);
                n_state   = S_INS;
            end
            S_RM_RD: begin
                if (r_idx == r_count) begin
                    n_res   = '{ols_pkg::NO_VALUE, ols_pkg::ST_MISS,
                                ols_pkg::LEN_W'(r_count)};
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(r_idx);
                    n_state   = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (r_rdata == r_value) begin
                    n_state = S_RM_SH;
                end else begin
                    n_idx   = idx_next;
                    n_state = S_RM_RD;
                end
            end
            S_RM_SH: begin
                if (idx_next == r_count) begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_res   = '{ols_pkg::NO_VALUE, ols_pkg::ST_DONE,
                                ols_pkg::LEN_W'(n_count)};
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(idx_next);
                    n_state   = S_RM_MV;
                end
            end
            S_RM_MV: begin
                // close the gap: pull the next entry toward the head
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(r_idx);
                mem_wdata = r_rdata;
                n_idx     = idx_next;
                n_state   = S_RM_SH;
            end
            S_RD: begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(r_idx);
                n_state   = S_RD_GET;
            end
            S_RD_GET: begin
                n_res   = '{r_rdata, ols_pkg::ST_DONE, ols_pkg::LEN_W'(r_count)};
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_res_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_tgt   <= n_tgt;
        r_value <= n_value;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

`include "ordered_list_store_assert.svh"

    `OLS_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `OLS_ASSERT(a_idx_bound, (r_state == S_IDLE) || (r_idx <= r_count), "index past list end")
    `OLS_ASSERT_NEXT(a_len_match, (r_state == S_DONE) && (!r_out_valid || i_res_ready), o_res_valid && (o_res.length == ols_pkg::LEN_W'(r_count)), "result length differs from count")
    `OLS_ASSERT_NEXT(a_count_hold, (r_state == S_IDLE) || (r_state == S_DONE), r_count == $past(r_count), "count changed outside an update")

endmodule
